@@ src/sfbu_pkg.sv @@
package sfbu_pkg;

   localparam int EXP_BITS    = 15;
   localparam int QUEUE_DEPTH = 4;
   localparam int DIV_BITS    = 17;
   localparam logic [14:0] CLAMP_STEPS = 15'd22528;
   localparam logic [63:0] EXP_BASE_Q32 = 64'd4278222805;

   typedef struct packed {
      logic        func;
      logic        neg;
      logic [14:0] k;
      logic [15:0] grad_out;
      logic [15:0] grad_acc;
   } item_type;

   // exp(-2^n/256) in Q0.32 by repeated rounded squaring
   function automatic logic [31:0] exp_base(input int n);
      logic [63:0] b;
      b = EXP_BASE_Q32;
      for (int i = 0; i < n; i++) begin
         b = (b * b + 64'h8000_0000) >> 32;
      end
      return b[31:0];
   endfunction

endpackage

@@ src/sigmoid_forward_backward_unit_core.sv @@
// Logistic sigmoid unit: y = 1/(1+exp(-x)) in Q0.16 and, for func 1, the
// accumulated gradient grad_acc + grad_out*y*(1-y) in saturating Q8.8. One
// transaction is accepted per clock and one result comes out per clock in
// steady state while results are taken. A transaction passes through 15
// exponent stages (one per bit of the clamped |x|, the first loaded straight
// from the queue), a divider setup stage, 17 quotient stages, two multiply
// stages and the output register. An input queue of
// QueueDepth entries absorbs stalls on the result side; the pipeline holds
// while a result is not taken.
module sigmoid_forward_backward_unit_core #(
   parameter int QueueDepth = sfbu_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // x, grad_out, grad_acc
   input  logic [0:0]  req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // y, grad_new
);

   logic               q_valid, q_pop;
   sfbu_pkg::item_type q_item;

   sfbu_front #(.QueueDepth(QueueDepth)) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_func     (req_tuser[0]),
      .in_x        (req_tdata[15:0]),
      .in_grad_out (req_tdata[31:16]),
      .in_grad_acc (req_tdata[47:32]),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   sfbu_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_y        (rsp_tdata[15:0]),
      .out_grad_new (rsp_tdata[31:16])
   );

endmodule

@@ src/sfbu_front.sv @@
module sfbu_front #(
   parameter int QueueDepth = sfbu_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic               in_func,
   input  logic [15:0]        in_x,
   input  logic [15:0]        in_grad_out,
   input  logic [15:0]        in_grad_acc,
   output logic               q_valid,
   output sfbu_pkg::item_type q_item,
   input  logic               q_pop
);

   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);

   sfbu_pkg::item_type mem_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   sfbu_pkg::item_type cls;
   logic [16:0] mag;
   logic push, pop;

   always_comb begin
      mag = in_x[15] ? (17'd0 - {in_x[15], in_x}) : {1'b0, in_x};
      cls.func     = in_func;
      cls.neg      = in_x[15];
      cls.k        = (mag > {2'b00, sfbu_pkg::CLAMP_STEPS}) ? sfbu_pkg::CLAMP_STEPS
                                                             : mag[14:0];
      cls.grad_out = in_grad_out;
      cls.grad_acc = in_grad_acc;
   end

   assign in_ready = (count_ff != CntW'(QueueDepth));
   assign q_valid  = (count_ff != '0);
   assign q_item   = mem_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

@@ src/sfbu_back.sv @@
module sfbu_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  sfbu_pkg::item_type q_item,
   output logic               q_pop,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [15:0]        out_y,
   output logic [15:0]        out_grad_new
);

   localparam int NE = sfbu_pkg::EXP_BITS;
   localparam int ND = sfbu_pkg::DIV_BITS;

   logic adv;
   logic out_valid_ff;

   assign adv       = !out_valid_ff || out_ready;
   assign q_pop     = adv;
   assign out_valid = out_valid_ff;

   // exp(-k/256): one stage per bit of k
   logic               ev_ff  [NE];
   sfbu_pkg::item_type eit_ff [NE];
   logic [31:0]        ee_ff  [NE];
   logic               eone_ff[NE];

   for (genvar s = 0; s < NE; s++) begin : g_exp
      localparam logic [31:0] B = sfbu_pkg::exp_base(s);
      logic               v_src, one_src, one_in;
      sfbu_pkg::item_type it_src;
      logic [31:0]        e_src, e_in;
      logic [63:0]        prod;
      if (s == 0) begin : g_first
         assign v_src   = q_valid;
         assign it_src  = q_item;
         assign e_src   = '0;
         assign one_src = 1'b1;
      end else begin : g_next
         assign v_src   = ev_ff[s-1];
         assign it_src  = eit_ff[s-1];
         assign e_src   = ee_ff[s-1];
         assign one_src = eone_ff[s-1];
      end
      always_comb begin
         prod   = e_src * B + 64'h8000_0000;
         e_in   = e_src;
         one_in = one_src;
         if (it_src.k[s]) begin
            one_in = 1'b0;
            e_in   = one_src ? B : prod[63:32];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            ev_ff[s] <= 1'b0;
         end else if (adv) begin
            ev_ff[s] <= v_src;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            eit_ff[s]  <= it_src;
            ee_ff[s]   <= e_in;
            eone_ff[s] <= one_in;
         end
      end
   end

   // divider setup: D = 1 + E, N = (1 or E) * 2^16 + D/2
   logic               pv_ff;
   sfbu_pkg::item_type pit_ff;
   logic [33:0]        pd_ff, pd_in;
   logic [ND-1:0]      pn_ff;
   logic [33:0]        pr_ff;
   logic [32:0]        ef;
   logic [49:0]        num;

   always_comb begin
      ef    = eone_ff[NE-1] ? 33'h1_0000_0000 : {1'b0, ee_ff[NE-1]};
      pd_in = 34'h1_0000_0000 + {1'b0, ef};
      num   = eit_ff[NE-1].neg ? ({1'b0, ef, 16'd0} + {16'd0, pd_in[33:1]})
                               : (50'h1_0000_0000_0000 + {16'd0, pd_in[33:1]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (adv) begin
         pv_ff <= ev_ff[NE-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pit_ff <= eit_ff[NE-1];
         pd_ff  <= pd_in;
         pn_ff  <= num[ND-1:0];
         pr_ff  <= {1'b0, num[49:ND]};
      end
   end

   // restoring division, one quotient bit per stage
   logic               dv_ff [ND];
   sfbu_pkg::item_type dit_ff[ND];
   logic [33:0]        dd_ff [ND];
   logic [ND-1:0]      dn_ff [ND];
   logic [33:0]        dr_ff [ND];
   logic [ND-1:0]      dq_ff [ND];

   for (genvar j = 0; j < ND; j++) begin : g_div
      logic               v_src;
      sfbu_pkg::item_type it_src;
      logic [33:0]        d_src, r_src, r2, r_in;
      logic [ND-1:0]      n_src, q_src, q_in;
      if (j == 0) begin : g_first
         assign v_src  = pv_ff;
         assign it_src = pit_ff;
         assign d_src  = pd_ff;
         assign n_src  = pn_ff;
         assign r_src  = pr_ff;
         assign q_src  = '0;
      end else begin : g_next
         assign v_src  = dv_ff[j-1];
         assign it_src = dit_ff[j-1];
         assign d_src  = dd_ff[j-1];
         assign n_src  = dn_ff[j-1];
         assign r_src  = dr_ff[j-1];
         assign q_src  = dq_ff[j-1];
      end
      always_comb begin
         r2 = {r_src[32:0], n_src[ND-1-j]};
         if (r2 >= d_src) begin
            r_in = r2 - d_src;
            q_in = {q_src[ND-2:0], 1'b1};
         end else begin
            r_in = r2;
            q_in = {q_src[ND-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j] <= 1'b0;
         end else if (adv) begin
            dv_ff[j] <= v_src;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dit_ff[j] <= it_src;
            dd_ff[j]  <= d_src;
            dn_ff[j]  <= n_src;
            dr_ff[j]  <= r_in;
            dq_ff[j]  <= q_in;
         end
      end
   end

   // p = yu * (1 - yu)
   logic               sv_ff;
   sfbu_pkg::item_type sit_ff;
   logic [ND-1:0]      syu_ff;
   logic [30:0]        sp_ff;
   logic [33:0]        p_full;

   assign p_full = 34'(dq_ff[ND-1]) * (34'h1_0000 - 34'(dq_ff[ND-1]));

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= 1'b0;
      end else if (adv) begin
         sv_ff <= dv_ff[ND-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sit_ff <= dit_ff[ND-1];
         syu_ff <= dq_ff[ND-1];
         sp_ff  <= p_full[30:0];
      end
   end

   // grad_out * p
   logic               mv_ff;
   sfbu_pkg::item_type mit_ff;
   logic [ND-1:0]      myu_ff;
   logic signed [47:0] mprod_ff, mprod_in;

   assign mprod_in = 48'($signed(sit_ff.grad_out)) * $signed({17'd0, sp_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= 1'b0;
      end else if (adv) begin
         mv_ff <= sv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mit_ff   <= sit_ff;
         myu_ff   <= syu_ff;
         mprod_ff <= mprod_in;
      end
   end

   // round, accumulate, saturate
   logic [47:0]        rnd;
   logic signed [16:0] sum;
   logic [15:0]        y_in, grad_in;
   logic [15:0]        y_ff, grad_ff;

   always_comb begin
      rnd  = mprod_ff + 48'h0000_8000_0000;
      sum  = {mit_ff.grad_acc[15], mit_ff.grad_acc} + {rnd[47], rnd[47:32]};
      y_in = myu_ff[ND-1] ? 16'hFFFF : myu_ff[15:0];
      if (!mit_ff.func) begin
         grad_in = mit_ff.grad_acc;
      end else if (sum > 17'sd32767) begin
         grad_in = 16'h7FFF;
      end else if (sum < -17'sd32768) begin
         grad_in = 16'h8000;
      end else begin
         grad_in = sum[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= mv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         y_ff    <= y_in;
         grad_ff <= grad_in;
      end
   end

   assign out_y        = y_ff;
   assign out_grad_new = grad_ff;

endmodule

@@ tb/sigmoid_forward_backward_unit_core_tb.sv @@
`timescale 1ns / 1ps

module sigmoid_forward_backward_unit_core_tb;

   typedef struct {
      logic        func;
      logic [15:0] x;
      logic [15:0] grad_out;
      logic [15:0] grad_acc;
      logic        known;
      logic [15:0] y;
      logic [15:0] grad_new;
   } stim_row_type;

   typedef struct {
      logic [15:0] y;
      logic [15:0] grad_new;
   } sig_result_type;

   localparam logic FUNC_FORWARD  = 1'b0;
   localparam logic FUNC_BACKWARD = 1'b1;
   localparam int   NUM_RANDOM    = 1330;
   localparam int   CYCLE_LIMIT   = 400000;
   localparam int   DRAIN_CYCLES  = 60;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;

   sig_result_type expected_q[$];
   int             mismatches;
   int             cycles;
   int             sent_fwd;
   int             sent_bwd;
   int             received;
   bit             quiet_phase;

   sigmoid_forward_backward_unit_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic logic [63:0] exp_neg_steps(input logic [14:0] k);
      logic [63:0] base;
      logic [63:0] acc;
      base = 64'd4278222805;
      acc  = 64'h1_0000_0000;
      for (int i = 0; i < 15; i++) begin
         if (k[i]) acc = (acc * base + 64'h8000_0000) >> 32;
         base = (base * base + 64'h8000_0000) >> 32;
      end
      return acc;
   endfunction

   function automatic sig_result_type sigmoid_grad(input logic func, input logic [15:0] x,
                                                   input logic [15:0] gout,
                                                   input logic [15:0] gacc);
      sig_result_type r;
      logic [15:0]    mag;
      logic [14:0]    k;
      logic [63:0]    e;
      logic [63:0]    d;
      logic [63:0]    yu;
      longint         p;
      longint         prod;
      longint         g;
      longint         sum;
      mag = x[15] ? -x : x;
      k   = (mag > 16'd22528) ? 15'd22528 : mag[14:0];
      e   = exp_neg_steps(k);
      d   = 64'h1_0000_0000 + e;
      if (!x[15]) yu = (64'h1_0000_0000_0000 + (d >> 1)) / d;
      else yu = ((e << 16) + (d >> 1)) / d;
      r.y = (yu > 64'd65535) ? 16'hFFFF : yu[15:0];
      sum = longint'($signed(gacc));
      if (func == FUNC_BACKWARD) begin
         p    = longint'(yu * (64'd65536 - yu));
         prod = longint'($signed(gout)) * p;
         g    = ((prod + (64'sd1 <<< 31)) >>> 32);
         sum  = sum + g;
         if (sum > 32767) sum = 32767;
         if (sum < -32768) sum = -32768;
      end
      r.grad_new = sum[15:0];
      return r;
   endfunction

   task automatic send_item(input stim_row_type row);
      sig_result_type r;
      r = sigmoid_grad(row.func, row.x, row.grad_out, row.grad_acc);
      if (row.known) begin
         r.y        = row.y;
         r.grad_new = row.grad_new;
      end
      if (!quiet_phase && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {row.grad_acc, row.grad_out, row.x};
      req_tuser  <= row.func;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_q.push_back(r);
      if (row.func == FUNC_BACKWARD) sent_bwd++;
      else sent_fwd++;
   endtask

   // sink side with random stall bursts
   initial begin
      int stall;
      stall = 0;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 11) == 0) begin
            stall = $urandom_range(1, 19) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      sig_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         received++;
         if (expected_q.size() == 0) begin
            $error("unexpected transaction: y %0d grad_new %0d",
                   rsp_tdata[15:0], $signed(rsp_tdata[31:16]));
            mismatches++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_tdata[15:0] !== want.y) begin
               $error("y: expected %0d actual %0d", want.y, rsp_tdata[15:0]);
               mismatches++;
            end
            if (rsp_tdata[31:16] !== want.grad_new) begin
               $error("grad_new: expected %0d actual %0d", $signed(want.grad_new),
                      $signed(rsp_tdata[31:16]));
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      stim_row_type table_rows[$];
      stim_row_type row;
      int           sel;
      mismatches  = 0;
      cycles      = 0;
      sent_fwd    = 0;
      sent_bwd    = 0;
      received    = 0;
      quiet_phase = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;

      //            func           x         gout      gacc      known y        grad_new
      table_rows = '{
         '{FUNC_FORWARD,  16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h8000, 16'h0000},
         '{FUNC_FORWARD,  16'h7FFF, 16'h0000, 16'h1234, 1'b1, 16'hFFFF, 16'h1234},
         '{FUNC_FORWARD,  16'h8000, 16'h0000, 16'h8000, 1'b1, 16'h0000, 16'h8000},
         '{FUNC_FORWARD,  16'h5800, 16'h7FFF, 16'h7FFF, 1'b1, 16'hFFFF, 16'h7FFF},
         '{FUNC_FORWARD,  16'hA800, 16'h8000, 16'hFFFF, 1'b1, 16'h0000, 16'hFFFF},
         '{FUNC_BACKWARD, 16'h7FFF, 16'h7FFF, 16'h0100, 1'b1, 16'hFFFF, 16'h0100},
         '{FUNC_BACKWARD, 16'h8000, 16'h8000, 16'hFF00, 1'b1, 16'h0000, 16'hFF00},
         '{FUNC_BACKWARD, 16'h0000, 16'h7FFF, 16'h7FFF, 1'b1, 16'h8000, 16'h7FFF},
         '{FUNC_BACKWARD, 16'h0000, 16'h8000, 16'h8000, 1'b1, 16'h8000, 16'h8000},
         '{FUNC_BACKWARD, 16'h0000, 16'h0400, 16'h0000, 1'b1, 16'h8000, 16'h0100},
         '{FUNC_BACKWARD, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
         '{FUNC_BACKWARD, 16'h0001, 16'h7FFF, 16'h7F00, 1'b0, 16'h0000, 16'h0000},
         '{FUNC_BACKWARD, 16'hFFFF, 16'h8000, 16'h8100, 1'b0, 16'h0000, 16'h0000},
         '{FUNC_FORWARD,  16'h0100, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
         '{FUNC_FORWARD,  16'hFF00, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
         '{FUNC_BACKWARD, 16'h0B00, 16'h1000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
         '{FUNC_BACKWARD, 16'h1100, 16'h7FFF, 16'h0000, 1'b0, 16'h0000, 16'h0000},
         '{FUNC_BACKWARD, 16'h57FF, 16'h7FFF, 16'h0000, 1'b0, 16'h0000, 16'h0000},
         '{FUNC_BACKWARD, 16'h5801, 16'h7FFF, 16'h0000, 1'b0, 16'h0000, 16'h0000},
         '{FUNC_FORWARD,  16'hA801, 16'h5555, 16'hAAAA, 1'b0, 16'h0000, 16'h0000},
         '{FUNC_FORWARD,  16'h57FF, 16'hAAAA, 16'h5555, 1'b0, 16'h0000, 16'h0000}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[i]) send_item(table_rows[i]);

      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n > NUM_RANDOM - 150) quiet_phase = 1'b1;
         row.known    = 1'b0;
         row.y        = '0;
         row.grad_new = '0;
         row.func     = 1'($urandom_range(0, 1));
         sel          = $urandom_range(0, 9);
         if (sel < 6) row.x = 16'($urandom_range(0, 4095) - 2048);
         else if (sel < 8) row.x = 16'($urandom_range(0, 65535));
         else row.x = $urandom_range(0, 1) ? 16'(16'h5800 + $urandom_range(0, 3) - 2)
                                            : 16'(16'hA800 + $urandom_range(0, 3) - 2);
         row.grad_out = 16'($urandom_range(0, 65535));
         row.grad_acc = ($urandom_range(0, 3) == 0)
                        ? ($urandom_range(0, 1) ? 16'(16'h7F00 + $urandom_range(0, 255))
                                                : 16'(16'h8000 + $urandom_range(0, 255)))
                        : 16'($urandom_range(0, 65535));
         send_item(row);
      end
      req_tvalid <= 1'b0;

      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d forward and %0d backward transactions, %0d results checked",
               sent_fwd, sent_bwd, received);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
